// File: design/dsu_pkg.sv
// Shared types, sizes and helpers for the disjoint-set engine.
// No dependencies; dsu_front, dsu_back and the top-level file import this package.
`default_nettype none

package dsu_pkg;

	// element index width fixed by the item fields
	localparam int unsigned IDX_W = 10;
	// number of elements held in the parent table
	localparam int unsigned NUM_ELEMS = 1024;
	// table rows actually reachable with an index of IDX_W bits
	localparam int unsigned MEM_DEPTH = (NUM_ELEMS < (2 ** IDX_W)) ? NUM_ELEMS : (2 ** IDX_W);
	localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// command queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic {
		OP_FIND  = 1'b0,
		OP_UNION = 1'b1
	} op_t;

	// one queued command
	typedef struct packed {
		op_t  op;
		idx_t elem_a;
		idx_t elem_b;
	} cmd_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	// back end status toward the front end
	typedef struct packed {
		logic clearing;
		logic pop;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMPRESS,
		ST_FINISH
	} back_state_t;

	// an element outside the table is a permanent root
	function automatic logic in_table(idx_t e);
		return 32'(e) < NUM_ELEMS;
	endfunction

	function automatic addr_t to_addr(idx_t e);
		return e[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/dsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dsu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: design/dsu_front.sv
// Front end: takes request words, classifies them and queues commands.
// Depends on dsu_pkg.
`default_nettype none

module dsu_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                kind,
	input  wire dsu_pkg::idx_t       elem_a,
	input  wire dsu_pkg::idx_t       elem_b,
	input  wire dsu_pkg::back_stat_t stat,
	output dsu_pkg::head_t           head
);
	import dsu_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	cmd_t              new_cmd;

	// no new word while the queue is full or the table is being cleared
	assign in_stall = (count_q == QCNT_W'(QDEPTH)) || stat.clearing;
	assign push     = in_valid && !in_stall;

	// classify the request
	always_comb begin
		new_cmd.op     = kind ? OP_UNION : OP_FIND;
		new_cmd.elem_a = elem_a;
		new_cmd.elem_b = elem_b;
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = ent_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (stat.pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !stat.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && stat.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

`default_nettype wire

// File: design/dsu_back.sv
// Back end: clears the parent table, walks and compresses paths, links roots,
// and holds the result word. Depends on dsu_pkg and dsu_ram.
`default_nettype none

module dsu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dsu_pkg::head_t  head,
	output dsu_pkg::back_stat_t  stat,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output dsu_pkg::idx_t        root,
	output logic                 joined
);
	import dsu_pkg::*;

	back_state_t state_q;
	back_state_t state_nxt;
	addr_t       clr_q;
	op_t         op_q;
	logic        second_q;
	idx_t        elem_b_q;
	idx_t        start_q;
	idx_t        cur_q;
	idx_t        walk_root_q;
	idx_t        root_a_q;
	idx_t        rd_elem_q;
	logic        out_valid_q;
	idx_t        out_root_q;
	logic        out_joined_q;

	idx_t        ram_rd_data;
	idx_t        parent;
	logic        at_root;
	logic        out_free;
	logic        link;
	idx_t        rd_elem;
	logic        wr_en;
	addr_t       wr_addr;
	idx_t        wr_data;

	// parent table
	dsu_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MEM_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (to_addr(rd_elem)),
		.rd_data (ram_rd_data)
	);

	// parent of the element read last cycle; outside the table it is itself
	assign parent   = in_table(rd_elem_q) ? ram_rd_data : rd_elem_q;
	assign at_root  = (parent == cur_q);
	assign out_free = !out_valid_q || !out_stall;
	assign link     = (op_q == OP_UNION) && (root_a_q != walk_root_q) && in_table(root_a_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head.valid) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (at_root) begin
					state_nxt = ST_COMPRESS;
				end
			end
			ST_COMPRESS: begin
				if (at_root) begin
					state_nxt = (op_q == OP_UNION && !second_q) ? ST_WALK : ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// table port controls and queue pop
	always_comb begin
		rd_elem       = cur_q;
		wr_en         = 1'b0;
		wr_addr       = to_addr(cur_q);
		wr_data       = walk_root_q;
		stat.clearing = 1'b0;
		stat.pop      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				stat.clearing = 1'b1;
				wr_en         = 1'b1;
				wr_addr       = clr_q;
				wr_data       = IDX_W'(clr_q);
			end
			ST_IDLE: begin
				rd_elem  = head.cmd.elem_a;
				stat.pop = head.valid;
			end
			ST_WALK: begin
				rd_elem = at_root ? start_q : parent;
			end
			ST_COMPRESS: begin
				if (at_root) begin
					rd_elem = elem_b_q;
				end else begin
					rd_elem = parent;
					wr_en   = in_table(cur_q);
				end
			end
			ST_FINISH: begin
				wr_en   = out_free && link;
				wr_addr = to_addr(root_a_q);
				wr_data = walk_root_q;
			end
			default: begin
				rd_elem = cur_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk datapath and result word
	always_ff @(posedge clk) begin
		rd_elem_q <= rd_elem;
		case (state_q)
			ST_IDLE: begin
				op_q     <= head.cmd.op;
				elem_b_q <= head.cmd.elem_b;
				start_q  <= head.cmd.elem_a;
				cur_q    <= head.cmd.elem_a;
				second_q <= 1'b0;
			end
			ST_WALK: begin
				if (at_root) begin
					walk_root_q <= cur_q;
					cur_q       <= start_q;
				end else begin
					cur_q <= parent;
				end
			end
			ST_COMPRESS: begin
				if (at_root) begin
					// keep the first root while the second set is walked
					if (!second_q) begin
						root_a_q <= walk_root_q;
					end
					second_q <= 1'b1;
					start_q  <= elem_b_q;
					cur_q    <= elem_b_q;
				end else begin
					cur_q <= parent;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_root_q   <= walk_root_q;
					out_joined_q <= link;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign root      = out_root_q;
	assign joined    = out_joined_q;

endmodule

`default_nettype wire

// File: design/disjoint_set_union_find.sv
// Disjoint-set engine with path compression. A find or a union gives its result
// word once the back end has walked and compressed the path of each element it
// names. The back end works one request at a time; up to two more requests wait
// in the command queue. After reset a clearing pass (one table row per cycle)
// sets every element to its own parent, with in_stall high throughout the pass.
`default_nettype none

module disjoint_set_union_find (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          kind,
	input  wire dsu_pkg::idx_t elem_a,
	input  wire dsu_pkg::idx_t elem_b,
	output logic               out_valid,
	input  wire logic          out_stall,
	output dsu_pkg::idx_t      root,
	output logic               joined
);
	import dsu_pkg::*;

	head_t      head;
	back_stat_t stat;

	// request intake and queue
	dsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.elem_a   (elem_a),
		.elem_b   (elem_b),
		.stat     (stat),
		.head     (head)
	);

	// table walker and result word
	dsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root),
		.joined    (joined)
	);

endmodule

`default_nettype wire

// File: sim/union_find_checker.sv
// Result checker for the disjoint-set engine: watches both channels, keeps its own
// parent table to predict each word, and compares field by field.
// Depends on dsu_pkg.
module union_find_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  logic          kind,
	input  dsu_pkg::idx_t elem_a,
	input  dsu_pkg::idx_t elem_b,
	input  logic          out_valid,
	input  logic          out_stall,
	input  dsu_pkg::idx_t root,
	input  logic          joined,
	output int            fail_count,
	output int            words_due
);
	import dsu_pkg::*;

	typedef struct packed {
		idx_t root;
		logic joined;
	} dsu_word_t;

	idx_t      parent_tbl [NUM_ELEMS];
	dsu_word_t due_words [$];
	int        fail_tally = 0;

	// an element outside the table stays its own parent
	function automatic idx_t parent_of(idx_t e);
		if (int'(e) < int'(NUM_ELEMS))
			return parent_tbl[e];
		return e;
	endfunction

	// writes outside the table are dropped
	function automatic bit set_parent(idx_t e, idx_t p);
		if (int'(e) >= int'(NUM_ELEMS))
			return 1'b0;
		parent_tbl[e] = p;
		return 1'b1;
	endfunction

	// walk up to the root, then point every node on the path at it
	function automatic idx_t find_compress(idx_t start);
		idx_t head;
		idx_t cur;
		idx_t nxt;
		int   steps;
		head = start;
		steps = 0;
		while (parent_of(head) != head && steps < int'(NUM_ELEMS)) begin
			head = parent_of(head);
			steps++;
		end
		cur = start;
		steps = 0;
		while (parent_of(cur) != cur && steps < int'(NUM_ELEMS)) begin
			nxt = parent_of(cur);
			void'(set_parent(cur, head));
			cur = nxt;
			steps++;
		end
		return head;
	endfunction

	// expected word of one request, updating the table as the engine does
	function automatic dsu_word_t predict_word(op_t op, idx_t a, idx_t b);
		dsu_word_t w;
		idx_t      ra;
		w.joined = 1'b0;
		if (op == OP_FIND) begin
			w.root = find_compress(a);
		end else begin
			ra = find_compress(a);
			w.root = find_compress(b);
			// first root goes under the second, no rank
			if (ra != w.root && set_parent(ra, w.root))
				w.joined = 1'b1;
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		dsu_word_t want;
		if (!arst_n) begin
			for (int k = 0; k < int'(NUM_ELEMS); k++)
				parent_tbl[k] = idx_t'(k);
			due_words.delete();
		end else begin
			// result side first: a word never answers a request of the same edge
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$display("%0t: unexpected word root=%0d joined=%0b", $time, root, joined);
					fail_tally++;
				end else begin
					want = due_words.pop_front();
					if (root !== want.root) begin
						$display("%0t: root mismatch expected=%0d actual=%0d",
							$time, want.root, root);
						fail_tally++;
					end
					if (joined !== want.joined) begin
						$display("%0t: joined mismatch expected=%0b actual=%0b",
							$time, want.joined, joined);
						fail_tally++;
					end
				end
			end
			// append the prediction at the tail of the queue
			if (in_valid && !in_stall)
				due_words = {due_words, predict_word(op_t'(kind), elem_a, elem_b)};
		end
		fail_count <= fail_tally;
		words_due <= due_words.size();
	end

endmodule

// File: sim/testbench.sv
// Top of the disjoint-set engine testbench: clock, reset, request stimulus,
// result stall pattern, watchdog and verdict.
// Depends on dsu_pkg, union_find_checker and disjoint_set_union_find.
module testbench;
	import dsu_pkg::*;

	localparam int RANDOM_WORDS = 730;
	localparam int POOL_SIZE = 64;
	localparam int HOLD_OFF = 400;
	localparam int IDLE_LIMIT = 50000;
	localparam int DRAIN_CYCLES = 64;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic kind;
	idx_t elem_a;
	idx_t elem_b;
	logic out_valid;
	logic out_stall;
	idx_t root;
	logic joined;
	int   fail_count;
	int   words_due;
	int   words_sent = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	disjoint_set_union_find DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root),
		.joined    (joined)
	);

	union_find_checker word_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.root       (root),
		.joined     (joined),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("disjoint_set_union_find verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// send one request, opening a new burst after a random gap when due
	task automatic offer(op_t op, idx_t a, idx_t b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= op;
		elem_a <= a;
		elem_b <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// result side stall pattern, with one long hold-off once words flow
	initial begin : receiver
		int phase;
		int span;
		int odds;
		out_stall <= 1'b0;
		do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
		phase = 0;
		forever begin
			if (phase == 3) begin
				odds = 100;
				span = HOLD_OFF;
			end else begin
				case ($urandom_range(0, 3))
				0: odds = 0;
				1: odds = 25;
				2: odds = 60;
				default: odds = 90;
				endcase
				span = $urandom_range(10, 150);
			end
			repeat (span) begin
				out_stall <= ($urandom_range(1, 100) <= odds);
				@(posedge clk);
			end
			phase++;
		end
	end

	initial begin : stimulus
		idx_t base;
		idx_t p;
		int   seg;
		int   span;
		int   target;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= 1'b0;
		elem_a <= '0;
		elem_b <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// lowest and highest elements, fresh and then joined
		offer(OP_FIND, 10'd0, 10'd0);
		offer(OP_FIND, 10'd1023, 10'd1023);
		offer(OP_UNION, 10'd0, 10'd1023);
		// union of a set with itself
		offer(OP_UNION, 10'd1023, 10'd0);
		// build a chain 1 -> 2 -> ... -> 10
		for (int k = 1; k < 10; k++)
			offer(OP_UNION, idx_t'(k), idx_t'(k + 1));
		// deep walk with compression, then the flattened path
		offer(OP_FIND, 10'd1, 10'd0);
		offer(OP_FIND, 10'd1, 10'd1023);
		offer(OP_UNION, 10'd10, 10'd1);
		offer(OP_UNION, 10'd5, 10'd0);
		offer(OP_FIND, 10'd2, 10'd0);
		// alternating, all-ones and neighbouring bit patterns on both fields
		offer(OP_UNION, 10'h2AA, 10'h155);
		offer(OP_FIND, 10'h155, 10'h2AA);
		offer(OP_UNION, 10'h3FF, 10'h3FF);
		offer(OP_UNION, 10'h200, 10'h1FF);

		// random segments: pool work, chain building and full range noise
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			seg = $urandom_range(0, 9);
			if (seg <= 5) begin
				base = idx_t'($urandom_range(0, 1024 - POOL_SIZE));
				span = $urandom_range(10, 40);
				repeat (span)
					offer(op_t'($urandom_range(0, 1)),
						idx_t'(base + $urandom_range(0, POOL_SIZE - 1)),
						idx_t'(base + $urandom_range(0, POOL_SIZE - 1)));
			end else if (seg == 6) begin
				p = idx_t'($urandom_range(0, 1023 - 41));
				span = $urandom_range(8, 40);
				for (int i = 0; i < span; i++)
					offer(OP_UNION, idx_t'(p + i), idx_t'(p + i + 1));
				offer(OP_FIND, p, idx_t'($urandom_range(0, 1023)));
			end else begin
				span = $urandom_range(5, 20);
				repeat (span)
					offer(op_t'($urandom_range(0, 1)), idx_t'($urandom_range(0, 1023)),
						idx_t'($urandom_range(0, 1023)));
			end
		end

		// drain outstanding words
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("disjoint_set_union_find verification clean");
		else
			$display("disjoint_set_union_find verification failed");
		$finish;
	end

endmodule
